@@ sv/apng_frame_repackager_crc32_core_macros.svh @@
// Assertion helpers for the frame repackager.
`ifndef APNG_FRAME_REPACKAGER_CRC32_CORE_MACROS_SVH
`define APNG_FRAME_REPACKAGER_CRC32_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked outside reset only.
`define APR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("repackager check failed");
// Checked at every edge, reset included.
`define APR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("repackager check failed");
`else
`define APR_ASSERT(lbl, prop)
`define APR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ sv/apr_pkg.sv @@
`default_nettype none

package apr_pkg;

  typedef enum logic [1:0] {
    OP_HEADER  = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_END     = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // header byte positions
  localparam logic [5:0] HDR_CRC_FIRST = 6'd12;
  localparam logic [5:0] HDR_DIM_FIRST = 6'd16;
  localparam logic [5:0] HDR_DIM_LAST  = 6'd23;
  localparam logic [5:0] HDR_CRC_LAST  = 6'd28;
  localparam logic [5:0] HDR_SUM_FIRST = 6'd29;
  localparam logic [5:0] HDR_SUM_LAST  = 6'd32;
  localparam logic [5:0] HDR_SAT       = 6'd33;

  // framing steps of a chunk: length 0..3, type 4..7, data 8, crc 9..12
  localparam logic [3:0] STEP_LEN0  = 4'd0;
  localparam logic [3:0] STEP_TYPE0 = 4'd4;
  localparam logic [3:0] STEP_TYPE3 = 4'd7;
  localparam logic [3:0] STEP_DATA  = 4'd8;
  localparam logic [3:0] STEP_CRC0  = 4'd9;
  localparam logic [3:0] STEP_LAST  = 4'd12;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction

  // "IDAT" / "IEND" type bytes
  function automatic logic [7:0] type_byte(input logic is_end, input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h49;
      2'd1: r = is_end ? 8'h45 : 8'h44;
      2'd2: r = is_end ? 8'h4E : 8'h41;
      default: r = is_end ? 8'h44 : 8'h54;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/apng_frame_repackager_crc32_core.sv @@
// An accepted item waits in the item register; the single byte emitter, with its byte-wide CRC-32
// update, moves its beats into the output register, one output beat per cycle while the output
// is ready. An item with n result beats holds the input until its last beat is emitted (header
// byte 1, payload byte 1 to 13, end of frame 12); opcode 3 is taken without producing beats.
// Reset (rst_ni low, async): stream empty, header position 0, CRC all ones, width/height 1.
`default_nettype none

`include "apng_frame_repackager_crc32_core_macros.svh"

module apng_frame_repackager_crc32_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // config write port
  input  wire logic                        cfg_we_i,
  input  wire logic [apr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [30:0]                 cfg_wdata_i,
  // input stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [39:0]                 s_axis_tdata,  // data_byte[7:0], chunk_length[38:8], pad
  input  wire logic [2:0]                  s_axis_tuser,  // opcode[1:0], first_of_chunk[2]
  input  wire logic                        s_axis_tlast,  // last_of_chunk
  // output stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // out_byte[7:0]
  output logic                             m_axis_tlast   // last_of_run
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [30:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 31'd1;
      height_q <= 31'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        apr_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_wdata_i;
        apr_pkg::REG_FRAME_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------------
  apr_pkg::op_e in_op;
  logic [7:0]   in_db;
  logic [30:0]  in_len;
  logic         in_first;
  logic         s_acc;

  assign in_op    = apr_pkg::op_e'(s_axis_tuser[1:0]);
  assign in_first = s_axis_tuser[2];
  assign in_db    = s_axis_tdata[7:0];
  assign in_len   = s_axis_tdata[38:8];
  assign s_acc    = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Item register: holds the accepted item while its beats are emitted.
  // step_q walks the chunk framing; header items are a single beat.
  // ---------------------------------------------------------------------------
  logic         job_vld_q;
  apr_pkg::op_e op_q;
  logic [7:0]   db_q;
  logic         last_q;
  logic [30:0]  len_q;
  logic [3:0]   step_q, step_d;

  // running state
  logic [5:0]  pos_q, pos_d;
  logic [31:0] crc_q, crc_d;

  // output register
  logic       out_vld_q;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  logic emit;       // a beat moves into the output register this cycle
  logic job_done;   // that beat is the item's last

  assign emit = job_vld_q && (!out_vld_q || m_axis_tready);

  // Next item enters as soon as the current one hands over its final beat.
  assign s_axis_tready = !job_vld_q || (emit && job_done);

  // ---------------------------------------------------------------------------
  // Beat generation
  // ---------------------------------------------------------------------------
  logic [31:0] crc_inv;
  logic [31:0] len32;
  logic [63:0] dims;
  logic [2:0]  dim_off;
  logic [5:0]  sum_off;
  logic [3:0]  crc_off;
  logic [3:0]  end_step;
  logic [31:0] hdr_base;

  assign crc_inv = ~crc_q;
  assign len32   = {1'b0, len_q};
  assign dims    = {1'b0, width_q, 1'b0, height_q};
  assign dim_off = pos_q[2:0];                       // 16..23 -> 0..7
  assign sum_off = pos_q - apr_pkg::HDR_SUM_FIRST;   // 29..32 -> 0..3
  assign crc_off = step_q - apr_pkg::STEP_CRC0;      // 9..12  -> 0..3
  assign hdr_base = (pos_q == apr_pkg::HDR_CRC_FIRST) ? apr_pkg::CRC_ONES : crc_q;

  // payload without closing byte ends on its data beat
  assign end_step = (op_q == apr_pkg::OP_PAYLOAD && !last_q) ? apr_pkg::STEP_DATA
                                                              : apr_pkg::STEP_LAST;

  always_comb begin
    out_byte_d = db_q;
    out_last_d = 1'b0;
    crc_d      = crc_q;
    pos_d      = pos_q;
    step_d     = step_q + 4'd1;
    job_done   = 1'b0;

    unique case (op_q)
      apr_pkg::OP_HEADER: begin
        job_done   = 1'b1;
        out_last_d = 1'b1;
        if (pos_q >= apr_pkg::HDR_DIM_FIRST && pos_q <= apr_pkg::HDR_DIM_LAST) begin
          out_byte_d = 8'(dims >> (6'd8 * (6'd7 - {3'd0, dim_off})));
        end else if (pos_q >= apr_pkg::HDR_SUM_FIRST && pos_q <= apr_pkg::HDR_SUM_LAST) begin
          out_byte_d = 8'(crc_inv >> (5'd8 * (5'd3 - {3'd0, sum_off[1:0]})));
        end
        if (pos_q >= apr_pkg::HDR_CRC_FIRST && pos_q <= apr_pkg::HDR_CRC_LAST) begin
          crc_d = apr_pkg::crc_byte(hdr_base, out_byte_d);
        end
        if (pos_q < apr_pkg::HDR_SAT) begin
          pos_d = pos_q + 6'd1;
        end
      end
      apr_pkg::OP_PAYLOAD, apr_pkg::OP_END: begin
        job_done   = (step_q == end_step);
        out_last_d = job_done;
        if (step_q < apr_pkg::STEP_TYPE0) begin
          // length word: chunk length, or zero for IEND
          out_byte_d = (op_q == apr_pkg::OP_END) ? 8'd0
                     : 8'(len32 >> (5'd8 * (5'd3 - {3'd0, step_q[1:0]})));
          if (step_q == apr_pkg::STEP_LEN0) begin
            crc_d = apr_pkg::CRC_ONES;
          end
        end else if (step_q <= apr_pkg::STEP_TYPE3) begin
          out_byte_d = apr_pkg::type_byte(op_q == apr_pkg::OP_END, step_q[1:0]);
          crc_d      = apr_pkg::crc_byte(crc_q, out_byte_d);
          // IEND has no data beat
          if (step_q == apr_pkg::STEP_TYPE3 && op_q == apr_pkg::OP_END) begin
            step_d = apr_pkg::STEP_CRC0;
          end
        end else if (step_q == apr_pkg::STEP_DATA) begin
          out_byte_d = db_q;
          crc_d      = apr_pkg::crc_byte(crc_q, db_q);
        end else begin
          out_byte_d = 8'(crc_inv >> (5'd8 * (5'd3 - {3'd0, crc_off[1:0]})));
          if (step_q == apr_pkg::STEP_LAST) begin
            crc_d = apr_pkg::CRC_ONES;
            if (op_q == apr_pkg::OP_END) begin
              pos_d = '0;
            end
          end
        end
      end
      default: begin
        // opcode 3 never makes the item register valid
        job_done = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      pos_q     <= '0;
      crc_q     <= apr_pkg::CRC_ONES;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
        pos_q     <= pos_d;
        crc_q     <= crc_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (s_acc) begin
        job_vld_q <= (in_op != apr_pkg::OP_NONE);
      end else if (emit && job_done) begin
        job_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
    end
    if (s_acc) begin
      op_q   <= in_op;
      db_q   <= in_db;
      last_q <= s_axis_tlast;
      len_q  <= in_len;
      // a payload byte inside an open chunk starts at its data beat
      step_q <= (in_op == apr_pkg::OP_PAYLOAD && !in_first) ? apr_pkg::STEP_DATA
                                                           : apr_pkg::STEP_LEN0;
    end else if (emit) begin
      step_q <= step_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `APR_ASSERT_ALWAYS(a_pos_sat, pos_q <= apr_pkg::HDR_SAT)
  `APR_ASSERT(a_step_range, job_vld_q |-> step_q <= apr_pkg::STEP_LAST)
  `APR_ASSERT(a_job_hold, (job_vld_q && !emit) |=> (job_vld_q && $stable(step_q)))
  `APR_ASSERT(a_end_clears,
    (emit && op_q == apr_pkg::OP_END && step_q == apr_pkg::STEP_LAST)
      |=> (pos_q == '0 && crc_q == apr_pkg::CRC_ONES))
  `APR_ASSERT(a_last_beat_frees, (emit && job_done) |-> s_axis_tready)

endmodule

`default_nettype wire

@@ sim/apng_frame_repackager_crc32_core_chk.sv @@
module apng_frame_repackager_crc32_core_chk (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [apr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [30:0]                 cfg_wdata_i,
  input  wire logic                        s_axis_tvalid,
  input  wire logic                        s_axis_tready,
  input  wire logic [39:0]                 s_axis_tdata,  // data_byte[7:0], chunk_length[38:8], pad
  input  wire logic [2:0]                  s_axis_tuser,  // opcode[1:0], first_of_chunk[2]
  input  wire logic                        s_axis_tlast,  // last_of_chunk
  input  wire logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  input  wire logic [7:0]                  m_axis_tdata,  // out_byte[7:0]
  input  wire logic                        m_axis_tlast,  // last_of_run
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               beats_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] TYPE_IDAT = "IDAT";
  localparam logic [31:0] TYPE_IEND = "IEND";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } png_beat_t;

  // shadow of the block state
  logic [5:0]  hdr_pos    = '0;
  logic [31:0] shadow_crc = apr_pkg::CRC_ONES;
  logic [30:0] width_reg  = 31'd1;
  logic [30:0] height_reg = 31'd1;

  png_beat_t   png_beats_due[$];
  logic [7:0]  run_bytes[$];
  int          fails = 0;
  int          beats = 0;

  // bit-serial PNG CRC-32, LSB first
  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ apr_pkg::CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) run_bytes.push_back(w[8*(3-i) +: 8]);
  endfunction

  function automatic void put_type(input logic [31:0] t);
    for (int i = 0; i < 4; i++) begin
      shadow_crc = crc_update(shadow_crc, t[8*(3-i) +: 8]);
      run_bytes.push_back(t[8*(3-i) +: 8]);
    end
  endfunction

  function automatic void predict_png_bytes(input apr_pkg::op_e op, input logic [7:0] db,
                                            input logic first, input logic last,
                                            input logic [30:0] clen);
    logic [7:0]  b;
    logic [5:0]  p;
    logic [31:0] dims;
    int          k;
    run_bytes.delete();
    p = hdr_pos;
    case (op)
      apr_pkg::OP_HEADER: begin
        b = db;
        k = int'(p) - int'(apr_pkg::HDR_DIM_FIRST);
        if (p >= apr_pkg::HDR_DIM_FIRST && p <= apr_pkg::HDR_DIM_LAST) begin
          dims = (k < 4) ? {1'b0, width_reg} : {1'b0, height_reg};
          b = dims[8*(3-(k%4)) +: 8];
        end else if (p >= apr_pkg::HDR_SUM_FIRST && p <= apr_pkg::HDR_SUM_LAST) begin
          dims = ~shadow_crc;
          b = dims[8*(3-(int'(p)-int'(apr_pkg::HDR_SUM_FIRST))) +: 8];
        end
        if (p == apr_pkg::HDR_CRC_FIRST) shadow_crc = apr_pkg::CRC_ONES;
        if (p >= apr_pkg::HDR_CRC_FIRST && p <= apr_pkg::HDR_CRC_LAST)
          shadow_crc = crc_update(shadow_crc, b);
        if (p < apr_pkg::HDR_SAT) hdr_pos = p + 6'd1;
        run_bytes.push_back(b);
      end
      apr_pkg::OP_PAYLOAD: begin
        if (first) begin
          shadow_crc = apr_pkg::CRC_ONES;
          put_word({1'b0, clen});
          put_type(TYPE_IDAT);
        end
        shadow_crc = crc_update(shadow_crc, db);
        run_bytes.push_back(db);
        if (last) begin
          put_word(~shadow_crc);
          shadow_crc = apr_pkg::CRC_ONES;
        end
      end
      apr_pkg::OP_END: begin
        shadow_crc = apr_pkg::CRC_ONES;
        put_word(32'd0);
        put_type(TYPE_IEND);
        put_word(~shadow_crc);
        shadow_crc = apr_pkg::CRC_ONES;
        hdr_pos = '0;
      end
      default: ;  // unused opcode: dropped
    endcase
    foreach (run_bytes[i]) png_beats_due.push_back({run_bytes[i], i == run_bytes.size() - 1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    png_beat_t due;
    if (!rst_ni) begin
      hdr_pos = '0;
      shadow_crc = apr_pkg::CRC_ONES;
      width_reg = 31'd1;
      height_reg = 31'd1;
      png_beats_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          apr_pkg::REG_FRAME_WIDTH:  width_reg = cfg_wdata_i;
          apr_pkg::REG_FRAME_HEIGHT: height_reg = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_png_bytes(apr_pkg::op_e'(s_axis_tuser[1:0]), s_axis_tdata[7:0],
                          s_axis_tuser[2], s_axis_tlast, s_axis_tdata[38:8]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (png_beats_due.size() == 0) begin
          $error("out_byte: unexpected beat, expected none, actual %02h", m_axis_tdata);
          fails++;
        end else begin
          due = png_beats_due.pop_front();
          if (m_axis_tdata !== due.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h", due.data, m_axis_tdata);
            fails++;
          end
          if (m_axis_tlast !== due.last) begin
            $error("last_of_run mismatch: expected %0d, actual %0d", due.last, m_axis_tlast);
            fails++;
          end
          beats++;
        end
      end
    end
    fail_count_o    <= fails;
    pending_o       <= png_beats_due.size();
    beats_checked_o <= beats;
  end

endmodule

@@ sim/apng_frame_repackager_crc32_core_tb.sv @@
module apng_frame_repackager_crc32_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TargetItems = 430;
  localparam int          CalmAfter   = 360;  // no idling once more than this many items went in
  localparam logic [30:0] DimMax      = 31'h7FFF_FFFF;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_we_i      = 1'b0;
  logic [apr_pkg::CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [30:0]                 cfg_wdata_i   = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [39:0]                 s_axis_tdata  = '0;  // data_byte[7:0], chunk_length[38:8], pad
  logic [2:0]                  s_axis_tuser  = '0;  // opcode[1:0], first_of_chunk[2]
  logic                        s_axis_tlast  = 1'b0;  // last_of_chunk
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [7:0]                  m_axis_tdata;  // out_byte[7:0]
  logic                        m_axis_tlast;  // last_of_run

  // idle_on gates the random gaps on both sides
  logic idle_on = 1'b1;
  int   stall_left = 0;

  int items_sent = 0;
  int frames_sent = 0;
  int size_settings = 0;
  int fail_count;
  int pending;
  int beats_checked;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  apng_frame_repackager_crc32_core dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  apng_frame_repackager_crc32_core_chk chk (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .beats_checked_o (beats_checked)
  );

  // Output backpressure: random stall bursts while idling is on.
  always @(posedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [30:0] rand_clen();
    return 31'($urandom());
  endfunction

  // One input beat. tvalid stays high between back-to-back beats, it only drops for a gap.
  task automatic send_beat(input apr_pkg::op_e op, input logic [7:0] db, input logic first,
                           input logic last, input logic [30:0] clen);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, clen, db};
    s_axis_tuser  <= {first, op};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op != apr_pkg::OP_NONE) items_sent++;
    // tail of the run: no more idling
    if (items_sent > CalmAfter) idle_on <= 1'b0;
  endtask

  // Drain: every predicted beat out, then a wait for a trailing ignored opcode.
  // pending is registered in the checker, hence the wait before it is first read.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One frame: header bytes, a few data chunks, end of frame.
  // A noisy frame gets a short or overlong header, broken chunk flags, stray beats
  // inside chunks and sometimes no end beat (header position then carries into the next frame).
  task automatic send_frame();
    int          hdr_len;
    int          chunks;
    int          len;
    int          pick;
    logic        noisy;
    logic        first;
    logic        last;
    logic [30:0] clen;
    noisy = ($urandom_range(0, 3) == 0);
    hdr_len = noisy ? $urandom_range(4, 40) : $urandom_range(33, 38);
    // header beats carry random flags and length too, the block must ignore them
    for (int i = 0; i < hdr_len; i++)
      send_beat(apr_pkg::OP_HEADER, 8'($urandom()), 1'($urandom()), 1'($urandom()),
                rand_clen());
    chunks = $urandom_range(1, 4);
    for (int c = 0; c < chunks; c++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
      // length field: mostly honest, sometimes zero or arbitrary (passed through unchecked)
      pick = $urandom_range(0, 9);
      clen = (pick == 0) ? rand_clen() : (pick == 1) ? 31'd0 : 31'(len);
      for (int i = 0; i < len; i++) begin
        first = (i == 0);
        last  = (i == len - 1);
        if (noisy && $urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 1) == 1) first = ~first;
          else last = ~last;
        end
        // stray header beat disturbs the open chunk's CRC when at position 12..28
        if (noisy && $urandom_range(0, 9) == 0)
          send_beat($urandom_range(0, 1) ? apr_pkg::OP_NONE : apr_pkg::OP_HEADER,
                    8'($urandom()), 1'($urandom()), 1'($urandom()), rand_clen());
        send_beat(apr_pkg::OP_PAYLOAD, 8'($urandom()), first, last, clen);
      end
    end
    if (!noisy || $urandom_range(0, 3) != 0)
      send_beat(apr_pkg::OP_END, 8'($urandom()), 1'($urandom()), 1'($urandom()),
                rand_clen());
    frames_sent++;
  endtask

  initial begin
    int          phase;
    logic [30:0] w;
    logic [30:0] h;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed beats, reset frame size ----
    // unused opcode with all fields high, then all low: no output, no state change
    send_beat(apr_pkg::OP_NONE, 8'hFF, 1'b1, 1'b1, DimMax);
    send_beat(apr_pkg::OP_NONE, 8'h00, 1'b0, 1'b0, 31'd0);
    // header bytes at the extremes, with flag/length noise
    send_beat(apr_pkg::OP_HEADER, 8'h00, 1'b1, 1'b1, DimMax);
    send_beat(apr_pkg::OP_HEADER, 8'hFF, 1'b0, 1'b0, 31'd0);
    // one-byte chunks: zero length field, max length field
    send_beat(apr_pkg::OP_PAYLOAD, 8'h00, 1'b1, 1'b1, 31'd0);
    send_beat(apr_pkg::OP_PAYLOAD, 8'hFF, 1'b1, 1'b1, DimMax);
    // three-byte chunk
    send_beat(apr_pkg::OP_PAYLOAD, 8'h5A, 1'b1, 1'b0, 31'd3);
    send_beat(apr_pkg::OP_PAYLOAD, 8'hA5, 1'b0, 1'b0, 31'd3);
    send_beat(apr_pkg::OP_PAYLOAD, 8'h3C, 1'b0, 1'b1, 31'd3);
    // payload with no opening beat: CRC runs on from the idle all-ones value
    send_beat(apr_pkg::OP_PAYLOAD, 8'h11, 1'b0, 1'b1, 31'd1);
    // bare payload byte, neither opening nor closing
    send_beat(apr_pkg::OP_PAYLOAD, 8'h22, 1'b0, 1'b0, 31'd7);
    // header byte inside an open chunk
    send_beat(apr_pkg::OP_PAYLOAD, 8'h33, 1'b1, 1'b0, 31'd2);
    send_beat(apr_pkg::OP_HEADER, 8'h44, 1'b1, 1'b0, 31'd5);
    send_beat(apr_pkg::OP_PAYLOAD, 8'h55, 1'b0, 1'b1, 31'd2);
    send_beat(apr_pkg::OP_END, 8'hFF, 1'b1, 1'b1, DimMax);
    // header counter back to zero after end of frame
    send_beat(apr_pkg::OP_HEADER, 8'h66, 1'b0, 1'b1, 31'd0);
    send_beat(apr_pkg::OP_END, 8'h00, 1'b0, 1'b0, 31'd0);
    wait_idle();

    // first full frame still with the reset width/height of 1
    send_frame();
    wait_idle();

    // ---- random frames, new frame size per phase ----
    phase = 0;
    while (items_sent < TargetItems) begin
      case (phase)
        0: begin w = DimMax; h = DimMax; end
        1: begin w = 31'd1;  h = DimMax; end
        2: begin w = DimMax; h = 31'd1;  end
        default: begin
          w = ($urandom_range(0, 2) == 0) ? rand_clen() : 31'($urandom_range(1, 4096));
          h = ($urandom_range(0, 2) == 0) ? rand_clen() : 31'($urandom_range(1, 4096));
          if (w == 31'd0) w = 31'd1;
          if (h == 31'd0) h = 31'd1;
        end
      endcase
      // some phases run without any idling; the tail of the run never idles
      idle_on <= (items_sent <= CalmAfter) && ($urandom_range(0, 3) != 0);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= apr_pkg::REG_FRAME_WIDTH;
      cfg_wdata_i <= w;
      @(posedge clk_i);
      cfg_idx_i   <= apr_pkg::REG_FRAME_HEIGHT;
      cfg_wdata_i <= h;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      size_settings++;
      repeat ($urandom_range(1, 2)) send_frame();
      wait_idle();
      phase++;
    end

    repeat (8) @(posedge clk_i);
    $display("Sent %0d input beats in %0d frames over %0d frame-size settings;",
             items_sent, frames_sent, size_settings);
    $display("checked %0d output beats against the predicted PNG stream.", beats_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("apng_frame_repackager_crc32_core verification clean");
    end else begin
      $display("apng_frame_repackager_crc32_core verification failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("apng_frame_repackager_crc32_core verification failed");
    $finish;
  end

endmodule
